@@ rtl/scrolling_sprite_compositor_assert.svh @@
// ----------------------------------------------------------------------------
// Scrolling sprite compositor assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SCROLLING_SPRITE_COMPOSITOR_ASSERT_SVH
`define SCROLLING_SPRITE_COMPOSITOR_ASSERT_SVH

// condition holds at every edge out of reset
`define SSC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("compositor invariant violated");

// consequent holds in the cycle after the antecedent
`define SSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("compositor sequence check failed");

`endif

@@ rtl/ssc_pkg.sv @@
// ----------------------------------------------------------------------------
// Scrolling sprite compositor package
// Geometry constants, request and result types, codes and store interface.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

    localparam int SCREEN_WIDTH      = 320;
    localparam int SCREEN_HEIGHT     = 240;
    localparam int SPRITE_MAX_WIDTH  = 64;
    localparam int SPRITE_MAX_HEIGHT = 64;
    localparam int SPRITE_FRAMES     = 2;

    localparam int BG_DEPTH   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int BG_AW      = $clog2(BG_DEPTH);
    localparam int SP_FRAME_SZ = SPRITE_MAX_WIDTH * SPRITE_MAX_HEIGHT;
    localparam int SP_DEPTH   = SPRITE_FRAMES * SP_FRAME_SZ;
    localparam int SP_AW      = (SP_DEPTH > 1) ? $clog2(SP_DEPTH) : 1;
    localparam int SP_XW      = $clog2(SPRITE_MAX_WIDTH);
    localparam int SP_YW      = $clog2(SPRITE_MAX_HEIGHT);
    localparam int OFF_W      = $clog2(SCREEN_WIDTH);
    localparam int FRAME_W    = (SPRITE_FRAMES > 1) ? $clog2(SPRITE_FRAMES) : 1;
    localparam int FCNT_W     = $clog2(SPRITE_FRAMES + 1) + 2;

    // coordinate arithmetic width: holds signed differences and screen limits
    localparam int CRD_W      = 11;

    // scroll speed reduction by reciprocal multiplication
    localparam int SPD_W       = 9;
    localparam int RECIP_SHIFT = 18;
    localparam int SPEED_RECIP = ((1 << RECIP_SHIFT) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
    localparam int RECIP_W     = 19;
    localparam int SPD_PROD_W  = SPD_W + RECIP_W;
    localparam int SPD_QW_W    = SPD_W + 11;

    localparam int PIX_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] KIND_BG_WRITE  = 2'd0;
    localparam logic [1:0] KIND_SP_WRITE  = 2'd1;
    localparam logic [1:0] KIND_NEW_FRAME = 2'd2;
    localparam logic [1:0] KIND_READ      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCROLL_SPEED  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd6;

    typedef struct packed {
        logic [1:0]       kind;
        logic [8:0]       col;
        logic [7:0]       row;
        logic             anim_frame;
        logic [PIX_W-1:0] pixel_in;
    } req_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             from_sprite;
    } rsp_t;

    typedef struct packed {
        logic             en;
        logic             bg_we;
        logic [BG_AW-1:0] bg_addr;
        logic             sp_we;
        logic [SP_AW-1:0] sp_addr;
        logic [PIX_W-1:0] wdata;
    } store_req_t;

    typedef struct packed {
        logic [OFF_W-1:0]   offset;
        logic [FRAME_W-1:0] shown;
    } frame_state_t;

endpackage

`default_nettype wire

@@ rtl/ssc_frame_ctl.sv @@
// ----------------------------------------------------------------------------
// Scrolling sprite compositor frame control
// Scroll offset and animation frame sequencing on each new-frame request.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_frame_ctl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [ssc_pkg::OFF_W-1:0]  speed_mod,
    input  wire logic [1:0]                 frame_count,
    output ssc_pkg::frame_state_t           state
);
    import ssc_pkg::*;

    logic [OFF_W-1:0]   offset_reg, offset_next;
    logic [FRAME_W-1:0] shown_reg, shown_next;
    logic [FRAME_W-1:0] upcoming_reg, upcoming_next;
    logic [OFF_W:0]     sum;
    logic [FCNT_W-1:0]  n_frames;
    logic [FCNT_W-1:0]  shown_inc;

    always_comb
    begin
        if (frame_count == 2'd0)
            n_frames = FCNT_W'(1);
        else if (FCNT_W'(frame_count) > FCNT_W'(SPRITE_FRAMES))
            n_frames = FCNT_W'(SPRITE_FRAMES);
        else
            n_frames = FCNT_W'(frame_count);

        sum = {1'b0, offset_reg} + {1'b0, speed_mod};
        if (sum >= (OFF_W+1)'(SCREEN_WIDTH))
            offset_next = OFF_W'(sum - (OFF_W+1)'(SCREEN_WIDTH));
        else
            offset_next = sum[OFF_W-1:0];

        if (FCNT_W'(upcoming_reg) < n_frames)
            shown_next = upcoming_reg;
        else
            shown_next = '0;

        shown_inc = FCNT_W'(shown_next) + FCNT_W'(1);
        if (shown_inc == n_frames)
            upcoming_next = '0;
        else
            upcoming_next = shown_inc[FRAME_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            shown_reg    <= '0;
            upcoming_reg <= '0;
        end
        else if (step)
        begin
            offset_reg   <= offset_next;
            shown_reg    <= shown_next;
            upcoming_reg <= upcoming_next;
        end
    end

    assign state.offset = offset_reg;
    assign state.shown  = shown_reg;

endmodule

`default_nettype wire

@@ rtl/ssc_store.sv @@
// ----------------------------------------------------------------------------
// Scrolling sprite compositor pixel stores
// Background frame store and sprite store, one access each per cycle while enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_store (
    input  wire logic                       clk,
    input  wire ssc_pkg::store_req_t        req,
    output logic [ssc_pkg::PIX_W-1:0]       bg_q,
    output logic [ssc_pkg::PIX_W-1:0]       sp_q
);
    import ssc_pkg::*;

    logic [PIX_W-1:0] bg_mem [BG_DEPTH];
    logic [PIX_W-1:0] sp_mem [SP_DEPTH];
    logic [PIX_W-1:0] bg_q_reg;
    logic [PIX_W-1:0] sp_q_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.bg_we)
                bg_mem[req.bg_addr] <= req.wdata;
            bg_q_reg <= bg_mem[req.bg_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.sp_we)
                sp_mem[req.sp_addr] <= req.wdata;
            sp_q_reg <= sp_mem[req.sp_addr];
        end
    end

    assign bg_q = bg_q_reg;
    assign sp_q = sp_q_reg;

endmodule

`default_nettype wire

@@ rtl/scrolling_sprite_compositor.sv @@
// ----------------------------------------------------------------------------
// Scrolling sprite compositor
// Color-keyed sprite overlay on a horizontally scrolling background store.
//
//   channel | signals                        | moves
//   --------+--------------------------------+-------------------------------
//   req     | req_valid, req_stall, req      | write, new frame or read
//   rsp     | rsp_valid, rsp_stall, rsp      | composite pixel per read
//   cfg     | cfg_we, cfg_index, cfg_data    | register write
//
// One request per cycle while req_stall is low; an accepted read passes through
// the request register, the store read port and the result register.
// Reset clears offset, frame state, config registers and valid flags; store contents stay unknown.
// A held result stalls every stage, so req_stall follows rsp_stall while a result is valid.
// ----------------------------------------------------------------------------
`default_nettype none

module scrolling_sprite_compositor (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire ssc_pkg::req_t                     req,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output ssc_pkg::rsp_t                          rsp,
    input  wire logic                              cfg_we,
    input  wire logic [ssc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ssc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ssc_pkg::*;

    logic [9:0]       sprite_left_reg;
    logic [9:0]       sprite_top_reg;
    logic [6:0]       sprite_width_reg;
    logic [6:0]       sprite_height_reg;
    logic [PIX_W-1:0] key_color_reg;
    logic [OFF_W-1:0] speed_mod_reg;
    logic [1:0]       frame_count_reg;

    logic [SPD_PROD_W-1:0] spd_prod;
    logic [SPD_W-1:0]      spd_quot;
    logic [SPD_QW_W-1:0]   spd_sub;
    logic [OFF_W-1:0]      speed_mod_next;

    logic             adv;
    logic             s1_valid_reg;
    req_t             s1_item_reg;
    logic             s2_valid_reg;
    logic             s2_read_reg;
    logic             s2_off_reg;
    logic             s2_inside_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg, rsp_next;

    frame_state_t     frame_st;
    store_req_t       st_req;
    logic [PIX_W-1:0] bg_q;
    logic [PIX_W-1:0] sp_q;

    logic [CRD_W-1:0] col_x;
    logic [CRD_W-1:0] row_x;
    logic [CRD_W-1:0] src_sum;
    logic [CRD_W-1:0] bg_col;
    logic [CRD_W-1:0] dx;
    logic [CRD_W-1:0] dy;
    logic [CRD_W-1:0] w_sat;
    logic [CRD_W-1:0] h_sat;
    logic             on_screen;
    logic             sp_wr_ok;
    logic             sp_hit;
    logic [SP_XW-1:0] sp_x;
    logic [SP_YW-1:0] sp_y;
    logic [SP_AW-1:0] sp_f;
    logic             s1_is_read;

    // reduce scroll speed modulo the screen width on write
    always_comb
    begin
        spd_prod = SPD_PROD_W'(cfg_data[SPD_W-1:0]) * SPD_PROD_W'(SPEED_RECIP);
        spd_quot = SPD_W'(spd_prod >> RECIP_SHIFT);
        spd_sub  = SPD_QW_W'(cfg_data[SPD_W-1:0])
                   - SPD_QW_W'(spd_quot) * SPD_QW_W'(SCREEN_WIDTH);
        speed_mod_next = spd_sub[OFF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_left_reg   <= '0;
            sprite_top_reg    <= '0;
            sprite_width_reg  <= 7'd64;
            sprite_height_reg <= 7'd64;
            key_color_reg     <= '0;
            speed_mod_reg     <= OFF_W'(3 % SCREEN_WIDTH);
            frame_count_reg   <= 2'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPRITE_LEFT:   sprite_left_reg   <= cfg_data[9:0];
                REG_SPRITE_TOP:    sprite_top_reg    <= cfg_data[9:0];
                REG_SPRITE_WIDTH:  sprite_width_reg  <= cfg_data[6:0];
                REG_SPRITE_HEIGHT: sprite_height_reg <= cfg_data[6:0];
                REG_KEY_COLOR:     key_color_reg     <= cfg_data[PIX_W-1:0];
                REG_SCROLL_SPEED:  speed_mod_reg     <= speed_mod_next;
                REG_FRAME_COUNT:   frame_count_reg   <= cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    assign adv       = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !adv;

    // address stage
    always_comb
    begin
        col_x      = CRD_W'(s1_item_reg.col);
        row_x      = CRD_W'(s1_item_reg.row);
        s1_is_read = (s1_item_reg.kind == KIND_READ);
        on_screen  = (col_x < CRD_W'(SCREEN_WIDTH)) && (row_x < CRD_W'(SCREEN_HEIGHT));
        sp_wr_ok   = (col_x < CRD_W'(SPRITE_MAX_WIDTH))
                     && (row_x < CRD_W'(SPRITE_MAX_HEIGHT))
                     && (FCNT_W'(s1_item_reg.anim_frame) < FCNT_W'(SPRITE_FRAMES));

        src_sum = col_x + CRD_W'(frame_st.offset);
        if (src_sum >= CRD_W'(SCREEN_WIDTH))
            src_sum = src_sum - CRD_W'(SCREEN_WIDTH);
        bg_col = s1_is_read ? src_sum : col_x;

        w_sat = (CRD_W'(sprite_width_reg) > CRD_W'(SPRITE_MAX_WIDTH))
                ? CRD_W'(SPRITE_MAX_WIDTH) : CRD_W'(sprite_width_reg);
        h_sat = (CRD_W'(sprite_height_reg) > CRD_W'(SPRITE_MAX_HEIGHT))
                ? CRD_W'(SPRITE_MAX_HEIGHT) : CRD_W'(sprite_height_reg);
        dx = col_x - {sprite_left_reg[9], sprite_left_reg};
        dy = row_x - {sprite_top_reg[9], sprite_top_reg};
        sp_hit = !dx[CRD_W-1] && !dy[CRD_W-1] && (dx < w_sat) && (dy < h_sat);

        if (s1_is_read)
        begin
            sp_x = dx[SP_XW-1:0];
            sp_y = dy[SP_YW-1:0];
            sp_f = SP_AW'(frame_st.shown);
        end
        else
        begin
            sp_x = s1_item_reg.col[SP_XW-1:0];
            sp_y = s1_item_reg.row[SP_YW-1:0];
            sp_f = SP_AW'(s1_item_reg.anim_frame);
        end

        st_req.en      = adv;
        st_req.bg_we   = s1_valid_reg && (s1_item_reg.kind == KIND_BG_WRITE) && on_screen;
        st_req.bg_addr = BG_AW'(row_x) * BG_AW'(SCREEN_WIDTH) + BG_AW'(bg_col);
        st_req.sp_we   = s1_valid_reg && (s1_item_reg.kind == KIND_SP_WRITE) && sp_wr_ok;
        st_req.sp_addr = sp_f * SP_AW'(SP_FRAME_SZ)
                         + SP_AW'(sp_y) * SP_AW'(SPRITE_MAX_WIDTH) + SP_AW'(sp_x);
        st_req.wdata   = s1_item_reg.pixel_in;
    end

    ssc_frame_ctl u_frame_ctl (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (adv && s1_valid_reg && (s1_item_reg.kind == KIND_NEW_FRAME)),
        .speed_mod   (speed_mod_reg),
        .frame_count (frame_count_reg),
        .state       (frame_st)
    );

    ssc_store u_store (
        .clk  (clk),
        .req  (st_req),
        .bg_q (bg_q),
        .sp_q (sp_q)
    );

    // composite select
    always_comb
    begin
        if (s2_off_reg)
        begin
            rsp_next.pixel_out   = '0;
            rsp_next.from_sprite = 1'b0;
        end
        else if (s2_inside_reg && (sp_q != key_color_reg))
        begin
            rsp_next.pixel_out   = sp_q;
            rsp_next.from_sprite = 1'b1;
        end
        else
        begin
            rsp_next.pixel_out   = bg_q;
            rsp_next.from_sprite = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= req_valid;
            s2_valid_reg  <= s1_valid_reg;
            rsp_valid_reg <= s2_valid_reg && s2_read_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg   <= req;
            s2_read_reg   <= s1_is_read;
            s2_off_reg    <= !on_screen;
            s2_inside_reg <= sp_hit;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`include "scrolling_sprite_compositor_assert.svh"

    `SSC_ASSERT_ALWAYS(a_offset_range, {1'b0, frame_st.offset} < (OFF_W+1)'(SCREEN_WIDTH))
    `SSC_ASSERT_ALWAYS(a_frame_range, FCNT_W'(frame_st.shown) < FCNT_W'(SPRITE_FRAMES))
    `SSC_ASSERT_NEXT(a_read_gives_result, adv && s2_valid_reg && s2_read_reg, rsp_valid_reg)
    `SSC_ASSERT_NEXT(a_write_no_result, adv && !(s2_valid_reg && s2_read_reg), !rsp_valid_reg)

endmodule

`default_nettype wire

@@ dv/scrolling_sprite_compositor_tb.sv @@
// ----------------------------------------------------------------------------
// Scrolling sprite compositor testbench
// Drives background writes, sprite writes, new-frame and read requests through
// the valid/stall request channel. A scoreboard keeps its own copy of the
// stores, scroll state and registers, predicts every composite pixel and
// checks results in order. Reads only touch store entries already written.
// Register settings change between phases while the block is idle, with
// random sender gaps and receiver stalls, and one long receiver hold-off.
// ----------------------------------------------------------------------------
module scrolling_sprite_compositor_tb;
    import ssc_pkg::*;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASES         = 8;
    localparam int PHASE_REQUESTS = 165;
    localparam int MAX_PRINTS     = 50;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    class pixel_scoreboard;
        logic [PIX_W-1:0] bg_mem [BG_DEPTH];
        bit               bg_set [BG_DEPTH];
        logic [PIX_W-1:0] sp_mem [SP_DEPTH];
        bit               sp_set [SP_DEPTH];
        int               offset;
        int               shown;
        int               upcoming;
        int               left;
        int               top;
        int               sp_w;
        int               sp_h;
        logic [PIX_W-1:0] key;
        int               speed;
        int               frame_count;
        rsp_t             pending_pixels [$];
        int               errors;

        function new();
            offset      = 0;
            shown       = 0;
            upcoming    = 0;
            left        = 0;
            top         = 0;
            sp_w        = 64;
            sp_h        = 64;
            key         = '0;
            speed       = 3;
            frame_count = 2;
            errors      = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("%0t ERROR %s", $time, msg);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SPRITE_LEFT:   left        = int'($signed(data[9:0]));
                REG_SPRITE_TOP:    top         = int'($signed(data[9:0]));
                REG_SPRITE_WIDTH:  sp_w        = int'(data[6:0]);
                REG_SPRITE_HEIGHT: sp_h        = int'(data[6:0]);
                REG_KEY_COLOR:     key         = data;
                REG_SCROLL_SPEED:  speed       = int'(data[8:0]);
                REG_FRAME_COUNT:   frame_count = int'(data[1:0]);
                default: ;
            endcase
        endfunction

        function int sprite_cols();
            return (sp_w > SPRITE_MAX_WIDTH) ? SPRITE_MAX_WIDTH : sp_w;
        endfunction

        function int sprite_rows();
            return (sp_h > SPRITE_MAX_HEIGHT) ? SPRITE_MAX_HEIGHT : sp_h;
        endfunction

        function int frames_in_use();
            if (frame_count == 0)
                return 1;
            return (frame_count > SPRITE_FRAMES) ? SPRITE_FRAMES : frame_count;
        endfunction

        function int shown_slot();
            return (shown < SPRITE_FRAMES) ? shown : 0;
        endfunction

        function int bg_index(int col, int row);
            return row * SCREEN_WIDTH + col;
        endfunction

        function int sp_index(int frm, int dx, int dy);
            return (frm * SPRITE_MAX_HEIGHT + dy) * SPRITE_MAX_WIDTH + dx;
        endfunction

        function bit in_sprite(int col, int row, output int dx, output int dy);
            dx = col - left;
            dy = row - top;
            return dx >= 0 && dy >= 0 && dx < sprite_cols() && dy < sprite_rows();
        endfunction

        function rsp_t composite_pixel(int col, int row);
            rsp_t p;
            int   dx;
            int   dy;
            int   slot;
            bit   hit;
            p = '0;
            if (col >= SCREEN_WIDTH || row >= SCREEN_HEIGHT)
                return p;
            hit = in_sprite(col, row, dx, dy);
            if (hit)
            begin
                slot = sp_index(shown_slot(), dx, dy);
                if (sp_mem[slot] != key)
                begin
                    p.pixel_out   = sp_mem[slot];
                    p.from_sprite = 1'b1;
                    return p;
                end
            end
            p.pixel_out = bg_mem[bg_index((col + offset) % SCREEN_WIDTH, row)];
            return p;
        endfunction

        function void note_request(req_t r);
            int n;
            int idx;
            case (r.kind)
                KIND_BG_WRITE:
                begin
                    if (r.col < SCREEN_WIDTH && r.row < SCREEN_HEIGHT)
                    begin
                        idx = bg_index(r.col, r.row);
                        bg_mem[idx] = r.pixel_in;
                        bg_set[idx] = 1'b1;
                    end
                end
                KIND_SP_WRITE:
                begin
                    if (r.col < SPRITE_MAX_WIDTH && r.row < SPRITE_MAX_HEIGHT &&
                        r.anim_frame < SPRITE_FRAMES)
                    begin
                        idx = sp_index(r.anim_frame, r.col, r.row);
                        sp_mem[idx] = r.pixel_in;
                        sp_set[idx] = 1'b1;
                    end
                end
                KIND_NEW_FRAME:
                begin
                    n        = frames_in_use();
                    offset   = (offset + speed) % SCREEN_WIDTH;
                    shown    = (upcoming < n) ? upcoming : 0;
                    upcoming = (shown + 1) % n;
                end
                default:
                    pending_pixels.push_back(composite_pixel(r.col, r.row));
            endcase
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending_pixels.size() == 0)
            begin
                report($sformatf("unexpected result pixel %h from_sprite %b",
                                 got.pixel_out, got.from_sprite));
                return;
            end
            want = pending_pixels.pop_front();
            if (got.pixel_out !== want.pixel_out)
                report($sformatf("pixel_out %h, expected %h", got.pixel_out, want.pixel_out));
            if (got.from_sprite !== want.from_sprite)
                report($sformatf("from_sprite %b, expected %b",
                                 got.from_sprite, want.from_sprite));
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    pixel_scoreboard sb = new();

    int cycles        = 0;
    int sent          = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_left     = 0;

    scrolling_sprite_compositor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // hold off for a requested stretch, otherwise stall at random
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp);
    end

    function automatic req_t make_req(logic [1:0] kind, int col, int row, int frm,
                                      logic [PIX_W-1:0] pix);
        req_t r;
        r.kind       = kind;
        r.col        = col[8:0];
        r.row        = row[7:0];
        r.anim_frame = frm[0];
        r.pixel_in   = pix;
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] with_noise(int value, int bits);
        logic [31:0] mask;
        mask = (32'd1 << bits) - 1;
        return CFG_DATA_W'(($urandom() & ~mask) | (value & mask));
    endfunction

    task automatic send(input req_t r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(r);
        sent++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // fill in the entries a read will touch, then read
    task automatic read_at(input int col, input int row);
        int dx;
        int dy;
        int src;
        bit hit;
        logic [PIX_W-1:0] pix;
        if (col < SCREEN_WIDTH && row < SCREEN_HEIGHT)
        begin
            src = (col + sb.offset) % SCREEN_WIDTH;
            if (!sb.bg_set[sb.bg_index(src, row)])
                send(make_req(KIND_BG_WRITE, src, row, $urandom_range(1), 16'($urandom())));
            hit = sb.in_sprite(col, row, dx, dy);
            if (hit && !sb.sp_set[sb.sp_index(sb.shown_slot(), dx, dy)])
            begin
                pix = ($urandom_range(3) == 0) ? sb.key : 16'($urandom());
                send(make_req(KIND_SP_WRITE, dx, dy, sb.shown_slot(), pix));
            end
        end
        send(make_req(KIND_READ, col, row, $urandom_range(1), 16'($urandom())));
    endtask

    task automatic random_read();
        int w;
        int h;
        int col;
        int row;
        w   = sb.sprite_cols();
        h   = sb.sprite_rows();
        col = -1;
        row = -1;
        if ($urandom_range(1) && w > 0 && h > 0)
        begin
            col = sb.left + $urandom_range(w - 1);
            row = sb.top + $urandom_range(h - 1);
        end
        if (col < 0 || col > 511 || row < 0 || row > 255)
        begin
            if ($urandom_range(9) < 8)
            begin
                col = $urandom_range(SCREEN_WIDTH - 1);
                row = $urandom_range(SCREEN_HEIGHT - 1);
            end
            else
            begin
                col = $urandom_range(511);
                row = $urandom_range(255);
            end
        end
        read_at(col, row);
    endtask

    task automatic send_ignored();
        int col;
        int row;
        if ($urandom_range(1))
        begin
            if ($urandom_range(1))
            begin
                col = $urandom_range(511, SCREEN_WIDTH);
                row = $urandom_range(255);
            end
            else
            begin
                col = $urandom_range(511);
                row = $urandom_range(255, SCREEN_HEIGHT);
            end
            send(make_req(KIND_BG_WRITE, col, row, $urandom_range(1), 16'($urandom())));
        end
        else
        begin
            if ($urandom_range(1))
            begin
                col = $urandom_range(511, SPRITE_MAX_WIDTH);
                row = $urandom_range(255);
            end
            else
            begin
                col = $urandom_range(511);
                row = $urandom_range(255, SPRITE_MAX_HEIGHT);
            end
            send(make_req(KIND_SP_WRITE, col, row, $urandom_range(1), 16'($urandom())));
        end
    endtask

    task automatic configure(input int phase);
        int l;
        int t;
        int w;
        int h;
        int spd;
        int fc;
        logic [PIX_W-1:0] k;
        case (phase)
            0:
            begin
                l = -512; t = -512; w = 127; h = 0; k = 16'hFFFF; spd = 511; fc = 0;
            end
            1:
            begin
                l = 511; t = 511; w = 64; h = 64; k = 16'h0000; spd = 0; fc = 3;
            end
            2:
            begin
                l = 300; t = 200; w = 64; h = 64; k = 16'($urandom()); spd = 319; fc = 1;
            end
            3:
            begin
                l = -20; t = -10; w = 1; h = 1; k = 16'h0000; spd = 1; fc = 2;
            end
            default:
            begin
                l   = int'($urandom_range(382)) - 63;
                t   = int'($urandom_range(302)) - 63;
                w   = $urandom_range(127);
                h   = $urandom_range(127);
                k   = 16'($urandom());
                spd = $urandom_range(511);
                fc  = $urandom_range(3);
            end
        endcase
        program_register(REG_SPRITE_LEFT, with_noise(l, 10));
        program_register(REG_SPRITE_TOP, with_noise(t, 10));
        program_register(REG_SPRITE_WIDTH, with_noise(w, 7));
        program_register(REG_SPRITE_HEIGHT, with_noise(h, 7));
        program_register(REG_KEY_COLOR, k);
        program_register(REG_SCROLL_SPEED, with_noise(spd, 9));
        program_register(REG_FRAME_COUNT, with_noise(fc, 2));
        program_register(REG_UNUSED, 16'($urandom()));
    endtask

    initial
    begin
        int   useful;
        int   mark;
        int   op;
        bit   noise;
        logic [PIX_W-1:0] pix;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(make_req(KIND_BG_WRITE, 0, 0, 0, 16'hFFFF));
        send(make_req(KIND_BG_WRITE, 319, 239, 1, 16'h0000));
        send(make_req(KIND_BG_WRITE, 511, 255, 1, 16'h1234));
        send(make_req(KIND_SP_WRITE, 0, 0, 0, 16'hA5A5));
        send(make_req(KIND_SP_WRITE, 63, 63, 1, 16'h5A5A));
        send(make_req(KIND_SP_WRITE, 64, 10, 0, 16'h7777));
        send(make_req(KIND_SP_WRITE, 511, 255, 1, 16'h8888));
        send(make_req(KIND_SP_WRITE, 1, 0, 0, 16'h0000));
        read_at(0, 0);
        read_at(319, 239);
        read_at(1, 0);
        read_at(320, 0);
        read_at(0, 240);
        read_at(511, 255);
        send(make_req(KIND_NEW_FRAME, 0, 0, 0, 16'h0000));
        send(make_req(KIND_NEW_FRAME, 511, 255, 1, 16'hFFFF));
        read_at(63, 63);
        read_at(318, 5);
        send(make_req(KIND_NEW_FRAME, 0, 0, 0, 16'h0000));
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            configure(p);
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 77; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 77; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            if (p == 0)
                hold_req = HOLD_CYCLES;
            useful = 0;
            while (useful < PHASE_REQUESTS)
            begin
                mark  = sent;
                noise = 1'b0;
                op    = $urandom_range(99);
                if (op < 55)
                    random_read();
                else if (op < 68)
                    send(make_req(KIND_BG_WRITE, $urandom_range(SCREEN_WIDTH - 1),
                                  $urandom_range(SCREEN_HEIGHT - 1), $urandom_range(1),
                                  16'($urandom())));
                else if (op < 80)
                begin
                    pix = ($urandom_range(9) < 3) ? sb.key : 16'($urandom());
                    send(make_req(KIND_SP_WRITE, $urandom_range(SPRITE_MAX_WIDTH - 1),
                                  $urandom_range(SPRITE_MAX_HEIGHT - 1),
                                  $urandom_range(1), pix));
                end
                else if (op < 88)
                    send(make_req(KIND_NEW_FRAME, $urandom_range(511), $urandom_range(255),
                                  $urandom_range(1), 16'($urandom())));
                else
                begin
                    noise = 1'b1;
                    send_ignored();
                end
                if (!noise)
                    useful += sent - mark;
            end
            drain();
        end

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
